@@ sv/rmq_pkg.sv @@
package rmq_pkg;

  // Element format: signed Q2.14 in 16 bits.
  localparam int unsigned ElemW  = 16;
  localparam int unsigned FracB  = 14;
  // Off-diagonal sums and differences need one more bit.
  localparam int unsigned DiffW  = ElemW + 1;
  // Wide signed width for the trace and the root argument.
  localparam int unsigned ArgW   = ElemW + 4;
  // The clamped root argument stays below 2^17.
  localparam int unsigned ArgUW  = 17;
  // Radicand is the argument shifted by FracB-2, padded to an even width.
  localparam int unsigned RadW   = 30;
  localparam int unsigned RootW  = RadW / 2;
  localparam int unsigned RemW   = RootW + 2;
  // Divider: denominator is 4*root, quotient never reaches 2^24.
  localparam int unsigned DenW   = RootW + 2;
  localparam int unsigned NumW   = 32;
  localparam int unsigned QuotW  = 24;
  localparam int unsigned DRemW  = DenW + 1;
  localparam int unsigned Lanes  = 3;

  // Which quaternion part carries the square root.
  localparam logic [1:0] SEL_W = 2'd0;
  localparam logic [1:0] SEL_X = 2'd1;
  localparam logic [1:0] SEL_Y = 2'd2;
  localparam logic [1:0] SEL_Z = 2'd3;

  typedef struct packed {
    logic signed [ElemW-1:0] m00;
    logic signed [ElemW-1:0] m01;
    logic signed [ElemW-1:0] m02;
    logic signed [ElemW-1:0] m10;
    logic signed [ElemW-1:0] m11;
    logic signed [ElemW-1:0] m12;
    logic signed [ElemW-1:0] m20;
    logic signed [ElemW-1:0] m21;
    logic signed [ElemW-1:0] m22;
  } in_word_t;

  typedef struct packed {
    logic signed [ElemW-1:0] quat_w;
    logic signed [ElemW-1:0] quat_x;
    logic signed [ElemW-1:0] quat_y;
    logic signed [ElemW-1:0] quat_z;
  } out_word_t;

  // Data that rides along the square root pipeline.
  typedef struct packed {
    logic [1:0]                   sel;
    logic [Lanes-1:0][DiffW-1:0]  d;
  } side_t;

  // Divider results handed to the output stage.
  typedef struct packed {
    logic [1:0]                   sel;
    logic [RootW-1:0]             root;
    logic [Lanes-1:0]             neg;
    logic [Lanes-1:0][QuotW-1:0]  quot;
  } div_res_t;

endpackage

@@ sv/rmq_front.sv @@
module rmq_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  rmq_pkg::in_word_t    word_i,
  output logic                 valid_o,
  output logic [rmq_pkg::RadW-1:0] rad_o,
  output rmq_pkg::side_t       side_o
);

  localparam int unsigned AW = rmq_pkg::ArgW;
  localparam int unsigned DW = rmq_pkg::DiffW;
  localparam logic signed [AW-1:0] One = AW'(1) <<< rmq_pkg::FracB;

  logic signed [AW-1:0] e00, e11, e22, tr, arg;
  logic signed [DW-1:0] e01, e02, e10, e12, e20, e21;
  logic [1:0]           sel;
  logic                 k1, k2;
  logic [rmq_pkg::ArgUW-1:0] arg_u;
  logic                 valid_q;
  logic [rmq_pkg::RadW-1:0] rad_d, rad_q;
  rmq_pkg::side_t       side_d, side_q;

  always_comb begin
    e00 = AW'(word_i.m00);
    e11 = AW'(word_i.m11);
    e22 = AW'(word_i.m22);
    e01 = DW'(word_i.m01);
    e02 = DW'(word_i.m02);
    e10 = DW'(word_i.m10);
    e12 = DW'(word_i.m12);
    e20 = DW'(word_i.m20);
    e21 = DW'(word_i.m21);
    tr  = e00 + e11 + e22;
    // Largest diagonal element, ties to the lower index.
    k1  = (word_i.m11 > word_i.m00);
    k2  = k1 ? (word_i.m22 > word_i.m11) : (word_i.m22 > word_i.m00);
    if (!tr[AW-1]) begin
      sel = rmq_pkg::SEL_W;
      arg = tr + One;
      side_d.d[0] = e21 - e12;
      side_d.d[1] = e02 - e20;
      side_d.d[2] = e10 - e01;
    end else if (k2) begin
      sel = rmq_pkg::SEL_Z;
      arg = e22 - e00 - e11 + One;
      side_d.d[0] = e02 + e20;
      side_d.d[1] = e12 + e21;
      side_d.d[2] = e10 - e01;
    end else if (k1) begin
      sel = rmq_pkg::SEL_Y;
      arg = e11 - e22 - e00 + One;
      side_d.d[0] = e21 + e12;
      side_d.d[1] = e01 + e10;
      side_d.d[2] = e02 - e20;
    end else begin
      sel = rmq_pkg::SEL_X;
      arg = e00 - e11 - e22 + One;
      side_d.d[0] = e10 + e01;
      side_d.d[1] = e20 + e02;
      side_d.d[2] = e21 - e12;
    end
    side_d.sel = sel;
    // The root argument is clamped to at least one LSB.
    if (arg[AW-1] || arg == '0) begin
      arg_u = rmq_pkg::ArgUW'(1);
    end else begin
      arg_u = arg[rmq_pkg::ArgUW-1:0];
    end
    rad_d = {{(rmq_pkg::RadW - rmq_pkg::ArgUW - (rmq_pkg::FracB - 2)){1'b0}}, arg_u,
             {(rmq_pkg::FracB - 2){1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

@@ sv/rmq_sqrt.sv @@
module rmq_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [rmq_pkg::RadW-1:0]  rad_i,
  input  rmq_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [rmq_pkg::RootW-1:0] root_o,
  output rmq_pkg::side_t            side_o
);

  localparam int unsigned N = rmq_pkg::RootW;

  typedef struct packed {
    logic [rmq_pkg::RadW-1:0]  rad;
    logic [rmq_pkg::RemW-1:0]  rem;
    logic [rmq_pkg::RootW-1:0] root;
    rmq_pkg::side_t            side;
  } sq_stage_t;

  sq_stage_t      st [N+1];
  logic [N:0]     vld;

  assign st[0].rad  = rad_i;
  assign st[0].rem  = '0;
  assign st[0].root = '0;
  assign st[0].side = side_i;
  assign vld[0]     = valid_i;

  // One result bit per stage, digit-by-digit square root.
  for (genvar s = 0; s < N; s++) begin : g_stage
    sq_stage_t nxt;
    logic [rmq_pkg::RemW-1:0] rem_sh, trial;
    always_comb begin
      rem_sh = {st[s].rem[rmq_pkg::RemW-3:0], st[s].rad[rmq_pkg::RadW-1 -: 2]};
      trial  = {st[s].root, 2'b01};
      nxt.rad  = {st[s].rad[rmq_pkg::RadW-3:0], 2'b00};
      nxt.side = st[s].side;
      if (rem_sh >= trial) begin
        nxt.rem  = rem_sh - trial;
        nxt.root = {st[s].root[N-2:0], 1'b1};
      end else begin
        nxt.rem  = rem_sh;
        nxt.root = {st[s].root[N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else if (en_i) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st[s+1] <= nxt;
      end
    end
  end

  assign valid_o = vld[N];
  assign root_o  = st[N].root;
  assign side_o  = st[N].side;

endmodule

@@ sv/rmq_div.sv @@
module rmq_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [rmq_pkg::RootW-1:0] root_i,
  input  rmq_pkg::side_t            side_i,
  output logic                      valid_o,
  output rmq_pkg::div_res_t         res_o
);

  localparam int unsigned N  = rmq_pkg::QuotW;
  localparam int unsigned L  = rmq_pkg::Lanes;
  localparam int unsigned DW = rmq_pkg::DiffW;

  typedef struct packed {
    logic [rmq_pkg::DenW-1:0]                den;
    logic [L-1:0][rmq_pkg::DRemW-1:0]        rem;
    logic [L-1:0][N-1:0]                     num;
    logic [L-1:0][N-1:0]                     quot;
    logic [L-1:0]                            neg;
    logic [rmq_pkg::RootW-1:0]               root;
    logic [1:0]                              sel;
  } dv_stage_t;

  dv_stage_t   st [N+2];
  dv_stage_t   prep;
  logic [N+1:0] vld;

  // Prepare: magnitude, rounding offset and the top numerator bits.
  always_comb begin
    logic [DW-1:0]               mag;
    logic [rmq_pkg::NumW-1:0]    num;
    prep.den  = {root_i, 2'b00};
    prep.root = root_i;
    prep.sel  = side_i.sel;
    for (int l = 0; l < L; l++) begin
      prep.neg[l] = side_i.d[l][DW-1];
      mag = side_i.d[l][DW-1] ? (~side_i.d[l] + DW'(1)) : side_i.d[l];
      num = rmq_pkg::NumW'({mag, {rmq_pkg::FracB{1'b0}}}) +
            rmq_pkg::NumW'(prep.den >> 1);
      prep.rem[l]  = rmq_pkg::DRemW'(num[rmq_pkg::NumW-1:N]);
      prep.num[l]  = num[N-1:0];
      prep.quot[l] = '0;
    end
  end

  assign vld[0] = valid_i;
  assign st[0]  = prep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld[1] <= 1'b0;
    end else if (en_i) begin
      vld[1] <= vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st[1] <= st[0];
    end
  end

  // One quotient bit per stage for each of the three lanes.
  for (genvar s = 1; s <= N; s++) begin : g_stage
    dv_stage_t nxt;
    always_comb begin
      logic [rmq_pkg::DRemW-1:0] rem_sh;
      nxt = st[s];
      for (int l = 0; l < L; l++) begin
        rem_sh = {st[s].rem[l][rmq_pkg::DRemW-2:0], st[s].num[l][N-1]};
        nxt.num[l] = {st[s].num[l][N-2:0], 1'b0};
        if (rem_sh >= {1'b0, st[s].den}) begin
          nxt.rem[l]  = rem_sh - {1'b0, st[s].den};
          nxt.quot[l] = {st[s].quot[l][N-2:0], 1'b1};
        end else begin
          nxt.rem[l]  = rem_sh;
          nxt.quot[l] = {st[s].quot[l][N-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else if (en_i) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st[s+1] <= nxt;
      end
    end
  end

  assign valid_o       = vld[N+1];
  assign res_o.sel     = st[N+1].sel;
  assign res_o.root    = st[N+1].root;
  assign res_o.neg     = st[N+1].neg;
  assign res_o.quot    = st[N+1].quot;

endmodule

@@ sv/rotation_matrix_to_quaternion_top.sv @@
// Channel | Direction | Handshake                  | Word
// input   | in        | in_valid_i / in_ready_o    | in_word_i  (nine matrix elements)
// output  | out       | out_valid_o / out_ready_i  | out_word_o (quaternion w, x, y, z)
//
// One matrix word enters per cycle while the output is not stalled. The pipeline holds
// one front stage, a 15-stage square root (one root bit per stage), a 25-stage divider
// (prep plus one quotient bit per stage) and the output register. Reset clears only
// the valid bits. A stall at the output freezes every stage at once, so nothing is
// lost or repeated and input ready follows.
module rotation_matrix_to_quaternion_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rmq_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rmq_pkg::out_word_t out_word_o
);

  localparam int unsigned EW = rmq_pkg::ElemW;
  localparam int unsigned QW = rmq_pkg::QuotW;

  // The whole pipeline advances whenever the output register is free or drained.
  logic                      en;
  logic                      fr_valid, sq_valid, dv_valid;
  logic [rmq_pkg::RadW-1:0]  fr_rad;
  rmq_pkg::side_t            fr_side, sq_side;
  logic [rmq_pkg::RootW-1:0] sq_root;
  rmq_pkg::div_res_t         dv_res;
  logic                      out_valid_q;
  rmq_pkg::out_word_t        out_word_d, out_word_q;
  logic [EW-1:0]             part [rmq_pkg::Lanes];
  logic [EW-1:0]             big;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  rmq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .word_i  (in_word_i),
    .valid_o (fr_valid),
    .rad_o   (fr_rad),
    .side_o  (fr_side)
  );

  rmq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .rad_i   (fr_rad),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  rmq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .root_i  (sq_root),
    .side_i  (sq_side),
    .valid_o (dv_valid),
    .res_o   (dv_res)
  );

  // Apply the sign and saturate a quotient magnitude to the signed element range.
  function automatic logic [EW-1:0] sat_part(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] lim_pos, lim_neg;
    lim_pos = QW'(1) << (EW - 1);
    lim_neg = lim_pos;
    lim_pos = lim_pos - QW'(1);
    if (neg) begin
      sat_part = (q >= lim_neg) ? {1'b1, {(EW-1){1'b0}}} : EW'(~q + QW'(1));
    end else begin
      sat_part = (q > lim_pos) ? {1'b0, {(EW-1){1'b1}}} : q[EW-1:0];
    end
  endfunction

  always_comb begin
    for (int l = 0; l < rmq_pkg::Lanes; l++) begin
      part[l] = sat_part(dv_res.quot[l], dv_res.neg[l]);
    end
    // The root is below 2^15, so it always fits the positive range.
    big = EW'(dv_res.root);
    case (dv_res.sel)
      rmq_pkg::SEL_W: begin
        out_word_d = {big, part[0], part[1], part[2]};
      end
      rmq_pkg::SEL_X: begin
        out_word_d = {part[2], big, part[0], part[1]};
      end
      rmq_pkg::SEL_Y: begin
        out_word_d = {part[2], part[1], big, part[0]};
      end
      rmq_pkg::SEL_Z: begin
        out_word_d = {part[2], part[0], part[1], big};
      end
      default: begin
        out_word_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ sv/rmq_checker.sv @@
module rmq_props (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i
);

  // A waiting output stays valid until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // Reset sampled low clears the output valid, so nothing is offered downstream.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

  // An empty output register never blocks the input.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // An output stall always stalls the input.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input accepted during output stall");

endmodule

bind rotation_matrix_to_quaternion_top rmq_props u_rmq_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i)
);
